FILE: src/sc1a_pkg.sv
package sc1a_pkg;

  // number of scan codes covered by the keymap
  localparam int KEYMAP_ENTRIES = 59;

  localparam int CODE_W = 7;
  localparam int BYTE_W = 8;

  // special bytes and key codes
  localparam logic [BYTE_W-1:0] PREFIX_EXT = 8'hE0;
  localparam logic [CODE_W-1:0] KEY_CTRL   = 7'h1D;
  localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [CODE_W-1:0] KEY_ALT    = 7'h38;
  localparam logic [CODE_W-1:0] KEY_CAPS   = 7'h3A;

  localparam logic [CODE_W-1:0] CHAR_LOW_A = 7'h61;
  localparam logic [CODE_W-1:0] CHAR_LOW_Z = 7'h7A;
  localparam logic [CODE_W-1:0] CASE_STEP  = 7'h20;

  // one keymap entry: normal and shifted character
  typedef struct packed {
    logic [CODE_W-1:0] shifted;
    logic [CODE_W-1:0] plain;
  } keymap_entry_t;

  // us layout keymap, zero where no character
  function automatic keymap_entry_t keymap_lookup(input logic [CODE_W-1:0] code);
    keymap_entry_t e;
    e = '{shifted: 7'h00, plain: 7'h00};
    unique case (code)
      7'h01: e = '{shifted: 7'h1B, plain: 7'h1B};
      7'h02: e = '{shifted: 7'h21, plain: 7'h31};
      7'h03: e = '{shifted: 7'h40, plain: 7'h32};
      7'h04: e = '{shifted: 7'h23, plain: 7'h33};
      7'h05: e = '{shifted: 7'h24, plain: 7'h34};
      7'h06: e = '{shifted: 7'h25, plain: 7'h35};
      7'h07: e = '{shifted: 7'h5E, plain: 7'h36};
      7'h08: e = '{shifted: 7'h26, plain: 7'h37};
      7'h09: e = '{shifted: 7'h2A, plain: 7'h38};
      7'h0A: e = '{shifted: 7'h28, plain: 7'h39};
      7'h0B: e = '{shifted: 7'h29, plain: 7'h30};
      7'h0C: e = '{shifted: 7'h5F, plain: 7'h2D};
      7'h0D: e = '{shifted: 7'h2B, plain: 7'h3D};
      7'h0E: e = '{shifted: 7'h08, plain: 7'h08};
      7'h0F: e = '{shifted: 7'h09, plain: 7'h09};
      7'h10: e = '{shifted: 7'h51, plain: 7'h71};
      7'h11: e = '{shifted: 7'h57, plain: 7'h77};
      7'h12: e = '{shifted: 7'h45, plain: 7'h65};
      7'h13: e = '{shifted: 7'h52, plain: 7'h72};
      7'h14: e = '{shifted: 7'h54, plain: 7'h74};
      7'h15: e = '{shifted: 7'h59, plain: 7'h79};
      7'h16: e = '{shifted: 7'h55, plain: 7'h75};
      7'h17: e = '{shifted: 7'h49, plain: 7'h69};
      7'h18: e = '{shifted: 7'h4F, plain: 7'h6F};
      7'h19: e = '{shifted: 7'h50, plain: 7'h70};
      7'h1A: e = '{shifted: 7'h7B, plain: 7'h5B};
      7'h1B: e = '{shifted: 7'h7D, plain: 7'h5D};
      7'h1C: e = '{shifted: 7'h0A, plain: 7'h0A};
      7'h1E: e = '{shifted: 7'h41, plain: 7'h61};
      7'h1F: e = '{shifted: 7'h53, plain: 7'h73};
      7'h20: e = '{shifted: 7'h44, plain: 7'h64};
      7'h21: e = '{shifted: 7'h46, plain: 7'h66};
      7'h22: e = '{shifted: 7'h47, plain: 7'h67};
      7'h23: e = '{shifted: 7'h48, plain: 7'h68};
      7'h24: e = '{shifted: 7'h4A, plain: 7'h6A};
      7'h25: e = '{shifted: 7'h4B, plain: 7'h6B};
      7'h26: e = '{shifted: 7'h4C, plain: 7'h6C};
      7'h27: e = '{shifted: 7'h3A, plain: 7'h3B};
      7'h28: e = '{shifted: 7'h22, plain: 7'h27};
      7'h29: e = '{shifted: 7'h7E, plain: 7'h60};
      7'h2B: e = '{shifted: 7'h7C, plain: 7'h5C};
      7'h2C: e = '{shifted: 7'h5A, plain: 7'h7A};
      7'h2D: e = '{shifted: 7'h58, plain: 7'h78};
      7'h2E: e = '{shifted: 7'h43, plain: 7'h63};
      7'h2F: e = '{shifted: 7'h56, plain: 7'h76};
      7'h30: e = '{shifted: 7'h42, plain: 7'h62};
      7'h31: e = '{shifted: 7'h4E, plain: 7'h6E};
      7'h32: e = '{shifted: 7'h4D, plain: 7'h6D};
      7'h33: e = '{shifted: 7'h3C, plain: 7'h2C};
      7'h34: e = '{shifted: 7'h3E, plain: 7'h2E};
      7'h35: e = '{shifted: 7'h3F, plain: 7'h2F};
      7'h37: e = '{shifted: 7'h2A, plain: 7'h2A};
      7'h39: e = '{shifted: 7'h20, plain: 7'h20};
      default: e = '{shifted: 7'h00, plain: 7'h00};
    endcase
    return e;
  endfunction

endpackage

FILE: src/scancode_set1_to_ascii.sv
// scan code set 1 to ascii translator, us layout
// each accepted input beat passes the rom register, then the output register
// throughput: one input beat per cycle; the keymap rom has a registered read
// and feeds a one-deep output register; input stalls only when both are full
// reset (synchronous, rst_n low) clears shift, caps lock and all valid flags
module scancode_set1_to_ascii
  import sc1a_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_scan_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_key_code,
  output logic [CODE_W-1:0] out_char_code
);

  logic              in_acc;
  logic              adv;
  logic              release_bit;
  logic [CODE_W-1:0] code;
  logic              is_prefix;
  logic              is_mod;
  logic              is_shift;
  logic              is_caps;
  logic              in_map;
  logic              cand;

  logic              shift_r, shift_nxt;
  logic              caps_r, caps_nxt;

  logic              s1_valid_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_shift_r;
  logic              s1_caps_r;
  keymap_entry_t     rom_q_r;

  logic [CODE_W-1:0] ch;
  logic              is_letter;
  logic              emit;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_key_r;
  logic [CODE_W-1:0] out_char_r;

  // handshake
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // decode the incoming byte
  assign release_bit = in_scan_byte[BYTE_W-1];
  assign code        = in_scan_byte[CODE_W-1:0];
  assign is_prefix   = (in_scan_byte == PREFIX_EXT);
  assign is_mod      = (code == KEY_CTRL) || (code == KEY_ALT);
  assign is_shift    = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);
  assign is_caps     = (code == KEY_CAPS);
  assign in_map      = ({1'b0, code} < BYTE_W'(KEYMAP_ENTRIES));
  assign cand        = !is_prefix && !is_mod && !is_shift && !is_caps
                       && !release_bit && in_map;

  // modifier flag update
  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    if (in_acc && !is_prefix && !is_mod) begin
      if (is_shift) begin
        shift_nxt = !release_bit;
      end else if (is_caps && !release_bit) begin
        caps_nxt = !caps_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

  // keymap rom read and lookup stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= cand;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rom_q_r    <= keymap_lookup(code);
      s1_code_r  <= code;
      s1_shift_r <= shift_r;
      s1_caps_r  <= caps_r;
    end
  end

  // apply shift and caps lock
  always_comb begin
    is_letter = (rom_q_r.plain >= CHAR_LOW_A) && (rom_q_r.plain <= CHAR_LOW_Z);
    ch        = rom_q_r.plain;
    if (is_letter) begin
      if (s1_shift_r != s1_caps_r) begin
        ch = rom_q_r.plain - CASE_STEP;
      end
    end else if (s1_shift_r && (rom_q_r.shifted != '0)) begin
      ch = rom_q_r.shifted;
    end
  end

  assign emit = s1_valid_r && (ch != '0);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_key_r  <= s1_code_r;
      out_char_r <= ch;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = out_key_r;
  assign out_char_code = out_char_r;

  // checks
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code != '0))
    else $error("result beat with zero character");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_shift_make: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !release_bit && is_shift) |=> shift_r)
    else $error("shift make did not set shift flag");

  a_shift_break: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && release_bit && is_shift) |=> !shift_r)
    else $error("shift break did not clear shift flag");

  a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !release_bit && is_caps) |=> (caps_r != $past(caps_r)))
    else $error("caps lock make did not toggle");

endmodule
